>>> src/hoc_pkg.sv
// ----------------------------------------------------------------------------
// hoc_pkg: shared types and constants of the hysteresis on/off controller
// Holds the configuration register set, the item and result records, and the
// register index codes of the configuration port.
// ----------------------------------------------------------------------------
package hoc_pkg;

    // Width of the configuration write data (widest register).
    localparam int unsigned CFG_DATA_W = 32;
    // Width of the configuration register index.
    localparam int unsigned CFG_ADDR_W = 3;

    // Milliseconds per second for the hold timer.
    localparam int unsigned MS_PER_SECOND = 1000;
    // Width of the hold time in milliseconds (65535 * 1000 fits in 26 bits).
    localparam int unsigned HOLD_MS_W = 26;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 72;

    // Bit positions inside mode_flags.
    localparam int unsigned MODE_ENABLED = 0;
    localparam int unsigned MODE_HIGH    = 1;
    localparam int unsigned MODE_SHOT    = 2;
    localparam int unsigned MODE_EXT     = 3;
    localparam int unsigned MODE_TIME    = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_HYSTERESIS = 3'd1,
        REG_ALARM_LOW  = 3'd2,
        REG_ALARM_HIGH = 3'd3,
        REG_MIN_HOLD   = 3'd4,
        REG_MODE_FLAGS = 3'd5
    } cfg_index_t;

    // Configuration register set.
    typedef struct packed {
        logic signed [31:0] setpoint;
        logic [30:0]        hysteresis;
        logic signed [31:0] alarm_low_limit;
        logic signed [31:0] alarm_high_limit;
        logic [15:0]        min_hold_seconds;
        logic [4:0]         mode_flags;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [31:0] reading;
        logic               reading_valid;
        logic               ext_enable;
        logic               startup;
        logic               silence_alarms;
    } item_t;

    // One result item.
    typedef struct packed {
        logic               drive;
        logic               holding;
        logic               alarm_low;
        logic               alarm_high;
        logic               alarm_any;
        logic signed [31:0] minimum_seen;
        logic signed [31:0] maximum_seen;
    } result_t;

endpackage

>>> src/hoc_cfg.sv
// ----------------------------------------------------------------------------
// hoc_cfg: configuration registers
// Decodes the plain write port into the six control registers of the loop.
// ----------------------------------------------------------------------------
module hoc_cfg
    import hoc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                REG_SETPOINT:   cfg_next.setpoint         = cfg_wdata;
                REG_HYSTERESIS: cfg_next.hysteresis       = cfg_wdata[30:0];
                REG_ALARM_LOW:  cfg_next.alarm_low_limit  = cfg_wdata;
                REG_ALARM_HIGH: cfg_next.alarm_high_limit = cfg_wdata;
                REG_MIN_HOLD:   cfg_next.min_hold_seconds = cfg_wdata[15:0];
                REG_MODE_FLAGS: cfg_next.mode_flags       = cfg_wdata[4:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/hoc_loop.sv
// ----------------------------------------------------------------------------
// hoc_loop: control loop state and single-pass update
// Evaluates one item against the loop state: band or window test, enable
// gating, minimum hold, alarms and running extremes. State advances on step.
// ----------------------------------------------------------------------------
module hoc_loop
    import hoc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    // Loop state.
    logic               drive_level_reg, drive_level_next;
    logic               shot_armed_reg, shot_armed_next;
    logic               hold_active_reg, hold_active_next;
    logic               last_level_reg, last_level_next;
    logic [31:0]        switch_stamp_reg, switch_stamp_next;
    logic signed [31:0] low_extreme_reg, low_extreme_next;
    logic signed [31:0] high_extreme_reg, high_extreme_next;
    logic               clear_pending_reg, clear_pending_next;

    // Mode bits.
    logic f_enabled, f_high, f_shot, f_ext, f_time;
    assign f_enabled = cfg.mode_flags[MODE_ENABLED];
    assign f_high    = cfg.mode_flags[MODE_HIGH];
    assign f_shot    = cfg.mode_flags[MODE_SHOT];
    assign f_ext     = cfg.mode_flags[MODE_EXT];
    assign f_time    = cfg.mode_flags[MODE_TIME];

    // Band test at doubled scale so the half band needs no rounding.
    logic signed [34:0] rd_x2, sp_x2, hy_35, band_lo, band_hi;
    assign rd_x2   = {{2{item.reading[31]}}, item.reading, 1'b0};
    assign sp_x2   = {{2{cfg.setpoint[31]}}, cfg.setpoint, 1'b0};
    assign hy_35   = {4'b0, cfg.hysteresis};
    assign band_lo = sp_x2 - hy_35;
    assign band_hi = sp_x2 + hy_35;

    // Window test for time mode: setpoint <= reading < setpoint + hysteresis.
    logic signed [33:0] rd_34, sp_34, win_end;
    logic               in_window;
    assign rd_34     = {{2{item.reading[31]}}, item.reading};
    assign sp_34     = {{2{cfg.setpoint[31]}}, cfg.setpoint};
    assign win_end   = sp_34 + {3'b0, cfg.hysteresis};
    assign in_window = (item.reading >= cfg.setpoint) && (rd_34 < win_end);

    // Requested level before enable gating.
    logic active;
    always_comb begin
        active = drive_level_reg;
        if (!item.reading_valid) begin
            active = 1'b0;
        end else if (f_time) begin
            active = in_window;
        end else begin
            if (rd_x2 < band_lo) begin
                active = !f_high;
            end
            if (rd_x2 > band_hi) begin
                active = f_high;
            end
        end
    end

    // Enable source: always on, external level, or latching one-shot.
    logic enable;
    logic shot_mid;
    always_comb begin
        enable          = 1'b0;
        shot_mid        = shot_armed_reg;
        shot_armed_next = shot_armed_reg;
        if (f_enabled) begin
            enable = 1'b1;
        end else if (f_ext) begin
            if (f_shot) begin
                if (!shot_armed_reg && active && item.ext_enable) begin
                    shot_mid = 1'b1;
                    enable   = 1'b1;
                end
                if (shot_mid && active && drive_level_reg) begin
                    enable = 1'b1;
                end
                shot_armed_next = shot_mid;
                if (shot_mid && !drive_level_reg && !item.ext_enable) begin
                    shot_armed_next = 1'b0;
                end
            end else begin
                enable = item.ext_enable;
            end
        end
    end

    // Drive level is frozen while a hold is in progress.
    assign drive_level_next = hold_active_reg ? drive_level_reg
                                              : (enable && item.reading_valid && active);

    // Minimum hold timer on wrapping millisecond stamps.
    logic [HOLD_MS_W-1:0] hold_ms;
    logic [31:0]          elapsed;
    logic [31:0]          stamp_tmp;
    assign hold_ms = HOLD_MS_W'(cfg.min_hold_seconds) * HOLD_MS_W'(MS_PER_SECOND);
    assign elapsed = item.now_ms - switch_stamp_reg;

    always_comb begin
        hold_active_next = hold_active_reg;
        last_level_next  = last_level_reg;
        stamp_tmp        = switch_stamp_reg;
        if (cfg.min_hold_seconds == '0) begin
            hold_active_next = 1'b0;
            stamp_tmp        = item.now_ms;
            last_level_next  = drive_level_next;
        end else if (hold_active_reg) begin
            if (elapsed > {{(32-HOLD_MS_W){1'b0}}, hold_ms}) begin
                hold_active_next = 1'b0;
                stamp_tmp        = item.now_ms;
            end
        end else if (last_level_reg != drive_level_next) begin
            stamp_tmp        = item.now_ms;
            hold_active_next = 1'b1;
            last_level_next  = drive_level_next;
        end else begin
            stamp_tmp = item.now_ms;
        end
        // A stamp ahead of the current time is pulled back to it.
        switch_stamp_next = (item.now_ms < stamp_tmp) ? item.now_ms : stamp_tmp;
    end

    // Range alarms; an invalid reading raises both unless alarms are gated.
    logic alo, ahi;
    always_comb begin
        alo = 1'b0;
        ahi = 1'b0;
        if (enable && !item.startup && !item.silence_alarms && !f_time) begin
            if (item.reading_valid) begin
                alo = item.reading < cfg.alarm_low_limit;
                ahi = item.reading > cfg.alarm_high_limit;
            end else begin
                alo = 1'b1;
                ahi = 1'b1;
            end
        end else if (f_time && !item.reading_valid) begin
            alo = 1'b1;
            ahi = 1'b1;
        end
    end

    // Running extremes; a clear or startup reseeds both with this reading.
    always_comb begin
        low_extreme_next   = low_extreme_reg;
        high_extreme_next  = high_extreme_reg;
        clear_pending_next = clear_pending_reg;
        if (item.reading_valid) begin
            if (item.reading < low_extreme_reg) begin
                low_extreme_next = item.reading;
            end
            if (item.reading > high_extreme_reg) begin
                high_extreme_next = item.reading;
            end
        end
        if (clear_pending_reg || item.startup) begin
            low_extreme_next   = item.reading;
            high_extreme_next  = item.reading;
            clear_pending_next = 1'b0;
        end
    end

    // State update, once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_level_reg   <= 1'b0;
            shot_armed_reg    <= 1'b0;
            hold_active_reg   <= 1'b0;
            last_level_reg    <= 1'b0;
            switch_stamp_reg  <= '0;
            low_extreme_reg   <= '0;
            high_extreme_reg  <= '0;
            clear_pending_reg <= 1'b1;
        end else if (step) begin
            drive_level_reg   <= drive_level_next;
            shot_armed_reg    <= shot_armed_next;
            hold_active_reg   <= hold_active_next;
            last_level_reg    <= last_level_next;
            switch_stamp_reg  <= switch_stamp_next;
            low_extreme_reg   <= low_extreme_next;
            high_extreme_reg  <= high_extreme_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

    // Result of this pass.
    always_comb begin
        result.drive        = drive_level_next;
        result.holding      = hold_active_next;
        result.alarm_low    = alo;
        result.alarm_high   = ahi;
        result.alarm_any    = alo || ahi;
        result.minimum_seen = low_extreme_next;
        result.maximum_seen = high_extreme_next;
    end

endmodule

>>> src/hysteresis_onoff_controller.sv
// ----------------------------------------------------------------------------
// hysteresis_onoff_controller: top level of the hysteresis on/off loop
// Data path: an accepted item is held in the input register, and its result is registered in the result register.
// Throughput: one item per cycle while m_tready keeps the result side open; the loop state update is one register pass.
// Reset: synchronous active-low aresetn clears the valid flags, configuration and loop state; extremes reseed.
// ----------------------------------------------------------------------------
module hysteresis_onoff_controller
    import hoc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms[31:0], reading[63:32], ext_enable[64], startup[65],
    // silence_alarms[66], zero pad[71:67]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // reading_valid[0]
    input  logic                   s_tuser,
    // Result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // drive[0], holding[1], alarm_low[2], alarm_high[3], alarm_any[4],
    // minimum_seen[36:5], maximum_seen[68:37], zero pad[71:69]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_item_reg;
    logic    out_valid_reg;
    result_t pass_result;
    logic    advance;

    hoc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held item moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.now_ms         <= s_tdata[31:0];
            in_item_reg.reading        <= s_tdata[63:32];
            in_item_reg.ext_enable     <= s_tdata[64];
            in_item_reg.startup        <= s_tdata[65];
            in_item_reg.silence_alarms <= s_tdata[66];
            in_item_reg.reading_valid  <= s_tuser;
        end
    end

    hoc_loop u_loop (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .item    (in_item_reg),
        .result  (pass_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= pass_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0,
                       out_item_reg.maximum_seen,
                       out_item_reg.minimum_seen,
                       out_item_reg.alarm_any,
                       out_item_reg.alarm_high,
                       out_item_reg.alarm_low,
                       out_item_reg.holding,
                       out_item_reg.drive};

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the hysteresis on/off controller
// Drives items on the input stream and configuration over the write port.
// A scoreboard class predicts each result from its own copy of the loop state
// and compares the result stream with it field by field. Both stream sides
// idle at random, and the result side also stalls for a long stretch twice.
// ----------------------------------------------------------------------------
module tb;
    import hoc_pkg::*;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    // Predicts the loop behavior and holds the results still to arrive.
    class loop_scoreboard;
        cfg_t               regs;
        logic               drive_lvl;
        logic               shot_armed;
        logic               hold_on;
        logic               last_lvl;
        logic               clear_due;
        logic [31:0]        switch_ms;
        logic signed [31:0] low_seen;
        logic signed [31:0] high_seen;
        result_t            due_q[$];
        int                 errors;
        int                 checked;
        int                 drive_cnt;
        int                 hold_cnt;
        int                 alarm_cnt;

        function new();
            regs       = '0;
            drive_lvl  = 1'b0;
            shot_armed = 1'b0;
            hold_on    = 1'b0;
            last_lvl   = 1'b0;
            clear_due  = 1'b1;
            switch_ms  = '0;
            low_seen   = '0;
            high_seen  = '0;
        endfunction

        function void apply_reg(cfg_index_t idx, logic [31:0] v);
            case (idx)
                REG_SETPOINT:   regs.setpoint         = v;
                REG_HYSTERESIS: regs.hysteresis       = v[30:0];
                REG_ALARM_LOW:  regs.alarm_low_limit  = v;
                REG_ALARM_HIGH: regs.alarm_high_limit = v;
                REG_MIN_HOLD:   regs.min_hold_seconds = v[15:0];
                REG_MODE_FLAGS: regs.mode_flags       = v[4:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_item(item_t it);
            longint      rd;
            longint      sp;
            longint      hy;
            logic [31:0] hold_ms;
            logic [31:0] elapsed;
            logic        prev;
            logic        act;
            logic        en;
            logic        alo;
            logic        ahi;
            logic        f_en;
            logic        f_high;
            logic        f_shot;
            logic        f_ext;
            logic        f_time;
            result_t     e;

            f_en   = regs.mode_flags[MODE_ENABLED];
            f_high = regs.mode_flags[MODE_HIGH];
            f_shot = regs.mode_flags[MODE_SHOT];
            f_ext  = regs.mode_flags[MODE_EXT];
            f_time = regs.mode_flags[MODE_TIME];
            rd = longint'($signed(it.reading));
            sp = longint'($signed(regs.setpoint));
            hy = longint'(regs.hysteresis);

            // The request: window test in time mode, else the hysteresis band.
            prev = drive_lvl;
            act  = prev;
            if (it.reading_valid) begin
                if (f_time) begin
                    act = (rd >= sp) && (rd < sp + hy);
                end else begin
                    if (2 * rd < 2 * sp - hy)
                        act = !f_high;
                    if (2 * rd > 2 * sp + hy)
                        act = f_high;
                end
            end else begin
                act = 1'b0;
            end

            // Enable source: always on, the external level, or a latching one-shot.
            en = 1'b0;
            if (f_en) begin
                en = 1'b1;
            end else if (f_ext) begin
                if (f_shot) begin
                    if (!shot_armed && act && it.ext_enable) begin
                        shot_armed = 1'b1;
                        en = 1'b1;
                    end
                    if (shot_armed && act && prev)
                        en = 1'b1;
                    if (shot_armed && !prev && !it.ext_enable)
                        shot_armed = 1'b0;
                end else begin
                    en = it.ext_enable;
                end
            end

            if (!hold_on)
                drive_lvl = en && it.reading_valid && act;

            // Minimum hold, timed with wrapping differences of the stamps.
            hold_ms = 32'(regs.min_hold_seconds) * MS_PER_SECOND;
            elapsed = it.now_ms - switch_ms;
            if (regs.min_hold_seconds == 0) begin
                hold_on   = 1'b0;
                switch_ms = it.now_ms;
                last_lvl  = drive_lvl;
            end else if (hold_on) begin
                if (elapsed > hold_ms) begin
                    hold_on   = 1'b0;
                    switch_ms = it.now_ms;
                end
            end else if (last_lvl != drive_lvl) begin
                switch_ms = it.now_ms;
                hold_on   = 1'b1;
                last_lvl  = drive_lvl;
            end else begin
                switch_ms = it.now_ms;
            end
            if (it.now_ms < switch_ms)
                switch_ms = it.now_ms;

            // Range alarms, or both alarms for an invalid reading unless alarms are gated.
            if (en && !it.startup && !it.silence_alarms && !f_time) begin
                if (it.reading_valid) begin
                    alo = $signed(it.reading) < $signed(regs.alarm_low_limit);
                    ahi = $signed(it.reading) > $signed(regs.alarm_high_limit);
                end else begin
                    alo = 1'b1;
                    ahi = 1'b1;
                end
            end else if (f_time && !it.reading_valid) begin
                alo = 1'b1;
                ahi = 1'b1;
            end else begin
                alo = 1'b0;
                ahi = 1'b0;
            end

            // Running extremes; a clear or startup reseeds them from this reading.
            if (it.reading_valid) begin
                if ($signed(it.reading) < low_seen)
                    low_seen = it.reading;
                if ($signed(it.reading) > high_seen)
                    high_seen = it.reading;
            end
            if (clear_due || it.startup) begin
                low_seen  = it.reading;
                high_seen = it.reading;
                clear_due = 1'b0;
            end

            e.drive        = drive_lvl;
            e.holding      = hold_on;
            e.alarm_low    = alo;
            e.alarm_high   = ahi;
            e.alarm_any    = alo | ahi;
            e.minimum_seen = low_seen;
            e.maximum_seen = high_seen;
            due_q.push_back(e);
        endfunction

        function void report_field(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(result_t got);
            result_t e;

            checked++;
            if (got.drive)
                drive_cnt++;
            if (got.holding)
                hold_cnt++;
            if (got.alarm_any)
                alarm_cnt++;
            if (due_q.size() == 0) begin
                $display("%0t: result with no item pending, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            e = due_q.pop_front();
            if (got.drive !== e.drive)
                report_field("drive", e.drive, got.drive);
            if (got.holding !== e.holding)
                report_field("holding", e.holding, got.holding);
            if (got.alarm_low !== e.alarm_low)
                report_field("alarm_low", e.alarm_low, got.alarm_low);
            if (got.alarm_high !== e.alarm_high)
                report_field("alarm_high", e.alarm_high, got.alarm_high);
            if (got.alarm_any !== e.alarm_any)
                report_field("alarm_any", e.alarm_any, got.alarm_any);
            if (got.minimum_seen !== e.minimum_seen)
                report_field("minimum_seen", e.minimum_seen, got.minimum_seen);
            if (got.maximum_seen !== e.maximum_seen)
                report_field("maximum_seen", e.maximum_seen, got.maximum_seen);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    // now_ms[31:0], reading[63:32], ext_enable[64], startup[65],
    // silence_alarms[66], zero pad[71:67]
    logic [IN_TDATA_W-1:0]  s_tdata;
    // reading_valid[0]
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // drive[0], holding[1], alarm_low[2], alarm_high[3], alarm_any[4],
    // minimum_seen[36:5], maximum_seen[68:37], zero pad[71:69]
    logic [OUT_TDATA_W-1:0] m_tdata;

    loop_scoreboard sb = new();

    // Stimulus state of the sender and the receiver.
    logic [31:0] now_gen;
    logic        ext_gen;
    bit          tx_free;
    bit          rx_free;
    bit          long_stall_req;
    int          items_sent;

    hysteresis_onoff_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Gap length in cycles: mostly none or short, now and then long.
    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random item: readings cluster about the band and window edges.
    function automatic item_t random_item();
        item_t  it;
        longint sp;
        longint hy;
        longint span;
        longint off;

        sp = longint'($signed(sb.regs.setpoint));
        hy = longint'(sb.regs.hysteresis);
        case ($urandom_range(0, 19))
            0:       now_gen = $urandom;
            1:       now_gen = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            default: now_gen = now_gen + $urandom_range(0, 600);
        endcase
        it.now_ms = now_gen;
        span = hy + 8;
        case ($urandom_range(0, 9))
            0, 1: it.reading = $urandom;
            2: begin
                if ($urandom_range(0, 1))
                    it.reading = sb.regs.alarm_low_limit + $urandom_range(0, 2) - 1;
                else
                    it.reading = sb.regs.alarm_high_limit + $urandom_range(0, 2) - 1;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0:       it.reading = 32'(sp - hy / 2);
                    1:       it.reading = 32'(sp + hy / 2);
                    2:       it.reading = 32'(sp + hy);
                    default: it.reading = 32'(sp);
                endcase
            end
            default: begin
                off = longint'($urandom) % (2 * span + 1) - span;
                it.reading = 32'(sp + off);
            end
        endcase
        it.reading_valid = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0)
            ext_gen = !ext_gen;
        it.ext_enable     = ext_gen;
        it.startup        = ($urandom_range(0, 29) == 0);
        it.silence_alarms = ($urandom_range(0, 9) == 0);
        return it;
    endfunction

    // Offers one item and waits for its handshake; enters and leaves at a falling edge.
    task automatic send_item(item_t it);
        int gap;
        gap = pick_gap(tx_free);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {5'b0, it.silence_alarms, it.startup, it.ext_enable, it.reading, it.now_ms};
        s_tuser  = it.reading_valid;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_fields(logic [31:0] now_ms, logic [31:0] reading, logic valid,
                               logic ext, logic startup, logic silence);
        item_t it;
        it.now_ms         = now_ms;
        it.reading        = reading;
        it.reading_valid  = valid;
        it.ext_enable     = ext;
        it.startup        = startup;
        it.silence_alarms = silence;
        send_item(it);
    endtask

    // Waits until every predicted result has come, then lets the pipeline settle.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] v);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = v;
        sb.apply_reg(idx, v);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(logic [31:0] sp, logic [31:0] hy, logic [31:0] alo,
                              logic [31:0] ahi, logic [31:0] hold, logic [31:0] mode);
        wait_idle();
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_HYSTERESIS, hy);
        write_reg(REG_ALARM_LOW, alo);
        write_reg(REG_ALARM_HIGH, ahi);
        write_reg(REG_MIN_HOLD, hold);
        write_reg(REG_MODE_FLAGS, mode);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_cnt > 0) begin
                m_tready = 1'b0;
                stall_cnt--;
            end else if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_tready = 1'b0;
                stall_cnt = 300;
            end else begin
                stall_cnt = pick_gap(rx_free);
                m_tready = (stall_cnt == 0);
                if (stall_cnt > 0)
                    stall_cnt--;
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.drive        = m_tdata[0];
            got.holding      = m_tdata[1];
            got.alarm_low    = m_tdata[2];
            got.alarm_high   = m_tdata[3];
            got.alarm_any    = m_tdata[4];
            got.minimum_seen = m_tdata[36:5];
            got.maximum_seen = m_tdata[68:37];
            sb.check_result(got);
        end
    end

    // Main sequence: reset, directed cases, then one random phase per mode setting.
    initial begin
        logic [31:0] sp;
        logic [31:0] hy;
        logic [31:0] alo;
        logic [31:0] ahi;
        logic [31:0] hold;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = REG_SETPOINT;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        now_gen        = '0;
        ext_gen        = 1'b0;
        tx_free        = 1'b0;
        rx_free        = 1'b0;
        long_stall_req = 1'b0;
        items_sent     = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // The first item reseeds the extremes even though its reading is invalid.
        send_fields(32'd0, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b0);

        // Always-on loop with a one second hold.
        set_config(10 * Q_ONE, 2 * Q_ONE, 5 * Q_ONE, 15 * Q_ONE, 1, 1 << MODE_ENABLED);
        send_fields(32'd100, 20 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd200, 8 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd300, 10 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd400, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd500, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd600, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_fields(32'd700, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1);
        send_fields(32'd1400, 20 * Q_ONE, 1'b1, 1'b0, 1'b1, 1'b0);
        send_fields(32'hFFFF_FFFF, 8 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'h0000_0010, 8 * Q_ONE, 1'b1, 1'b1, 1'b0, 1'b0);
        send_fields(32'd5, 9 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);

        // Time mode: on inside the window, alarms only for an invalid reading.
        set_config(10 * Q_ONE, 4 * Q_ONE, 0, 0, 0,
                   (1 << MODE_ENABLED) | (1 << MODE_TIME) | (1 << MODE_HIGH));
        send_fields(32'd2000, 10 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd2100, 14 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd2200, 13 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd2300, 9 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd2400, 12 * Q_ONE, 1'b0, 1'b0, 1'b0, 1'b0);

        // External enable level.
        set_config(10 * Q_ONE, 2 * Q_ONE, 0, 20 * Q_ONE, 0, 1 << MODE_EXT);
        send_fields(32'd3000, 5 * Q_ONE, 1'b1, 1'b1, 1'b0, 1'b0);
        send_fields(32'd3100, 5 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);

        // One-shot: arms on the enable, stays on while requested, drops after.
        set_config(10 * Q_ONE, 2 * Q_ONE, 0, 20 * Q_ONE, 0, (1 << MODE_EXT) | (1 << MODE_SHOT));
        send_fields(32'd3200, 5 * Q_ONE, 1'b1, 1'b1, 1'b0, 1'b0);
        send_fields(32'd3300, 5 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
        send_fields(32'd3400, 15 * Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);

        // No enable source at all.
        set_config(10 * Q_ONE, 2 * Q_ONE, 0, 20 * Q_ONE, 0, 0);
        send_fields(32'd3500, 5 * Q_ONE, 1'b1, 1'b1, 1'b0, 1'b0);

        // Random phases, one per mode value, with register extremes in some.
        now_gen = 32'd4000;
        for (int p = 0; p < 32; p++) begin
            sp   = (p == 5) ? 32'h8000_0000 : (p == 9) ? 32'h7FFF_FFFF :
                   $urandom_range(0, 200 << 16) - (100 << 16);
            hy   = (p == 6 || p == 9) ? 32'h7FFF_FFFF : (p % 7 == 3) ? 32'd0 :
                   $urandom_range(0, 6 << 16);
            alo  = (p == 10) ? 32'h8000_0000 : (p == 11) ? 32'h7FFF_FFFF :
                   sp - $urandom_range(0, 20 << 16);
            ahi  = (p == 10) ? 32'h7FFF_FFFF : (p == 12) ? 32'h8000_0000 :
                   sp + $urandom_range(0, 20 << 16);
            hold = (p == 13 || p == 29) ? 32'd65535 : (p % 3 == 0) ? 32'd0 :
                   $urandom_range(1, 2);
            tx_free = (p % 5 == 4);
            rx_free = (p % 5 == 4);
            set_config(sp, hy, alo, ahi, hold, p);
            for (int k = 0; k < 40; k++) begin
                // The receiver holds off while the sender keeps offering items.
                if ((p == 2 || p == 20) && k == 5)
                    long_stall_req = 1'b1;
                // The sender pauses until every result is in.
                if (p == 7 && k == 20)
                    wait_idle();
                send_item(random_item());
            end
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        $display("Sent %0d items: directed cases and 32 random phases, one per mode value.",
                 items_sent);
        $display("Checked %0d results: %0d with drive on, %0d holding, %0d with an alarm.",
                 sb.checked, sb.drive_cnt, sb.hold_cnt, sb.alarm_cnt);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #(12 * 500000);
        $display("Timeout with %0d results still pending.", sb.pending());
        $display("FAILURE");
        $finish;
    end

endmodule
